// ===== sv/llst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llst_pkg: shared types and constants of the least-loaded server table
// Table depth, derived index widths, command and status codes, entry layout.
// ----------------------------------------------------------------------------
package llst_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int LOAD_W   = 16;
  localparam int STATUS_W = 3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEREGISTER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // One table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic [LOAD_W-1:0] load;
  } entry_t;

endpackage

// ===== sv/least_loaded_server_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_server_table: server table with least-load selection
// Register, deregister and least-loaded lookup over an ordered table of
// servers, scanned one entry per cycle through a single compare unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  command   in         start high, busy low      cmd_i, ip_addr_i, port_i
//  result    out        done_o, one-cycle strobe  status_o, found_ip_o,
//                                                  found_port_o, found_load_o
//
//  A command scans the N stored entries, N being the entry count (at most 16);
//  a hit ends a register or deregister scan early. A deregister that removes
//  an entry then moves each entry behind it down one place, moving one entry
//  per cycle; one entry is read and compared per cycle.
//  Reset empties the table at once; no clearing pass. busy is set once a
//  command is accepted and falls as the result strobe is raised. Results cannot be stalled.
// ----------------------------------------------------------------------------
module least_loaded_server_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [llst_pkg::CMD_W-1:0]    cmd_i,
  input  logic [llst_pkg::ADDR_W-1:0]   ip_addr_i,
  input  logic [llst_pkg::PORT_W-1:0]   port_i,
  output logic                          done_o,
  output logic [llst_pkg::STATUS_W-1:0] status_o,
  output logic [llst_pkg::ADDR_W-1:0]   found_ip_o,
  output logic [llst_pkg::PORT_W-1:0]   found_port_o,
  output logic [llst_pkg::LOAD_W-1:0]   found_load_o
);
  import llst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHIFT
  } state_e;

  state_e              state_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [ADDR_W-1:0]   key_addr_q;
  logic [PORT_W-1:0]   key_port_q;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    issue_q;
  logic                pend_q;
  logic [IDX_W-1:0]    pend_idx_q;
  logic                match_q;
  logic [IDX_W-1:0]    match_idx_q;
  entry_t              best_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [ADDR_W-1:0]   found_ip_q;
  logic [PORT_W-1:0]   found_port_q;
  logic [LOAD_W-1:0]   found_load_q;

  // Entry memory
  entry_t              mem [TABLE_DEPTH];
  entry_t              rdata_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;

  // Shared compare unit
  logic                key_hit;
  logic                load_less;
  logic                last_pend;
  logic [LOAD_W-1:0]   best_load_inc;
  logic                accept;

  assign accept    = start && !busy;
  assign key_hit   = (rdata_q.addr == key_addr_q) && (rdata_q.port == key_port_q);
  assign load_less = rdata_q.load < best_q.load;
  assign last_pend = pend_q && (CNT_W'(pend_idx_q) == count_q - CNT_W'(1));
  assign best_load_inc = (best_q.load == '1) ? best_q.load : best_q.load + LOAD_W'(1);

  // Memory write port: append, load update, or move-down during removal
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata_q;
    case (state_q)
      S_ACT: begin
        if (cmd_q == CMD_REGISTER) begin
          mem_we    = !match_q && (count_q != CNT_W'(TABLE_DEPTH));
          mem_waddr = count_q[IDX_W-1:0];
          mem_wdata = '{addr: key_addr_q, port: key_port_q, load: '0};
        end else if (cmd_q == CMD_LOOKUP) begin
          mem_we    = (count_q != '0);
          mem_waddr = best_idx_q;
          mem_wdata = '{addr: best_q.addr, port: best_q.port, load: best_load_inc};
        end
      end
      S_SHIFT: begin
        mem_we    = pend_q;
        mem_waddr = pend_idx_q - IDX_W'(1);
        mem_wdata = rdata_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[issue_q[IDX_W-1:0]];
  end

  // Sequencer, counters and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      issue_q      <= '0;
      pend_q       <= 1'b0;
      pend_idx_q   <= '0;
      match_q      <= 1'b0;
      match_idx_q  <= '0;
      best_idx_q   <= '0;
      cmd_q        <= '0;
      done_q       <= 1'b0;
      status_q     <= ST_OK;
      found_ip_q   <= '0;
      found_port_q <= '0;
      found_load_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd_i;
            key_addr_q <= ip_addr_i;
            key_port_q <= port_i;
            issue_q    <= '0;
            pend_q     <= 1'b0;
            match_q    <= 1'b0;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read per cycle, compare the one read last cycle
          if (issue_q < count_q) begin
            issue_q <= issue_q + CNT_W'(1);
          end
          pend_q     <= issue_q < count_q;
          pend_idx_q <= issue_q[IDX_W-1:0];
          if (count_q == '0 || last_pend) begin
            state_q <= S_ACT;
          end
          if (pend_q) begin
            if (cmd_q == CMD_LOOKUP) begin
              if (pend_idx_q == '0 || load_less) begin
                best_q     <= rdata_q;
                best_idx_q <= pend_idx_q;
              end
            end else if ((cmd_q == CMD_REGISTER || cmd_q == CMD_DEREGISTER)
                         && key_hit) begin
              match_q     <= 1'b1;
              match_idx_q <= pend_idx_q;
              state_q     <= S_ACT;
            end
          end
        end
        S_ACT: begin
          found_ip_q   <= '0;
          found_port_q <= '0;
          found_load_q <= '0;
          status_q     <= ST_OK;
          done_q       <= 1'b1;
          state_q      <= S_IDLE;
          case (cmd_q)
            CMD_REGISTER: begin
              if (match_q) begin
                status_q <= ST_DUP;
              end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
                status_q <= ST_FULL;
              end else begin
                count_q <= count_q + CNT_W'(1);
              end
            end
            CMD_DEREGISTER: begin
              if (!match_q) begin
                status_q <= ST_NOTFOUND;
              end else begin
                // close the gap: entries behind the hit move down one place
                done_q  <= 1'b0;
                issue_q <= CNT_W'(match_idx_q) + CNT_W'(1);
                pend_q  <= 1'b0;
                state_q <= S_SHIFT;
              end
            end
            CMD_LOOKUP: begin
              if (count_q == '0) begin
                status_q <= ST_EMPTY;
              end else begin
                found_ip_q   <= best_q.addr;
                found_port_q <= best_q.port;
                found_load_q <= best_load_inc;
              end
            end
            default: begin
              status_q <= ST_OK;
            end
          endcase
        end
        S_SHIFT: begin
          if (issue_q < count_q) begin
            issue_q <= issue_q + CNT_W'(1);
          end
          pend_q     <= issue_q < count_q;
          pend_idx_q <= issue_q[IDX_W-1:0];
          if (!(issue_q < count_q) && !pend_q) begin
            count_q  <= count_q - CNT_W'(1);
            status_q <= ST_OK;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign found_ip_o   = found_ip_q;
  assign found_port_o = found_port_q;
  assign found_load_o = found_load_q;

`ifndef SYNTHESIS
  // table never holds more entries than it has rows
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // an accepted transaction makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result strobe only comes once the sequencer has returned to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe outside of end of transaction");

  // only a successful lookup reports a server
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (found_ip_o == '0 && found_load_o == '0))
    else $error("server reported on failed transaction");
`endif

endmodule
